### design/rpts_pkg.sv
// Shared types and constants of the rate paced transfer segmenter.
package rpts_pkg;

  // shared divider widths
  localparam int unsigned DIV_W = 40;
  localparam int unsigned DSR_W = 20;

  // result kinds
  localparam logic [2:0] RK_HEAD  = 3'd0;
  localparam logic [2:0] RK_BODY  = 3'd1;
  localparam logic [2:0] RK_TAIL  = 3'd2;
  localparam logic [2:0] RK_ADDED = 3'd3;
  localparam logic [2:0] RK_FULL  = 3'd4;
  localparam logic [2:0] RK_ZERO  = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_RATE = 2'd0;
  localparam logic [1:0] CFG_MIN_PKT  = 2'd1;
  localparam logic [1:0] CFG_MAX_PKT  = 2'd2;

  // header overheads and payload floor, bytes
  localparam logic [15:0] HDR_HEAD = 16'd13;
  localparam logic [15:0] HDR_BODY = 16'd2;
  localparam logic [15:0] HDR_TAIL = 16'd3;
  localparam logic [15:0] PAY_MIN  = 16'd10;

  localparam logic [9:0]  MS_PER_S = 10'd1000;
  localparam logic [19:0] LO_MUL   = 20'd10;
  localparam logic [19:0] HI_MUL   = 20'd15;

  // floor(x / 1000) = (x * RCP) >> shift, exact over the whole input range
  localparam logic [24:0] RCP_RATE = 25'd17179870;  // 24-bit x, shift 34
  localparam logic [26:0] RCP_FRAC = 27'd68719477;  // 26-bit x, shift 36

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ADD,
    OP_CLR_OWING,
    OP_TICK,
    OP_POP,
    OP_FLOOR,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_MUL,
    OP_FRAC,
    OP_CREDIT,
    OP_PKT,
    OP_PKT_DONE,
    OP_CRED_DONE,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic pop_cond;
    logic count_one;
    logic scan_last;
    logic div_done;
    logic pkt_interp;
    logic emit_end;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [14:0] id;
    logic [31:0] size;
    logic [23:0] rate;
    logic [15:0] category;
  } entry_t;

endpackage

### design/rpts_div.sv
// Radix-2 restoring divider shared by the tick arithmetic.
module rpts_div import rpts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic [DIV_W-1:0] quo_o,
  output logic [DSR_W-1:0] rem_o,
  output logic             done_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q, dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DSR_W:0]   sh, diff;
  logic             ge;

  always_comb begin
    sh   = {rem_q, quo_q[DIV_W-1]};
    ge   = sh >= {1'b0, dsr_q};
    diff = sh - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DIV_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DSR_W-1:0] : sh[DSR_W-1:0];
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

### design/rpts_dp.sv
// Datapath: config registers, descriptor queue, tick arithmetic and result register.
module rpts_dp import rpts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH          = 16,
  parameter int unsigned MAX_PACKETS_PER_TICK = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [31:0] total_size_i,
  input  logic [23:0] send_rate_i,
  input  logic [15:0] category_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [2:0]  result_kind_o,
  output logic [14:0] transfer_id_o,
  output logic [31:0] data_offset_o,
  output logic [15:0] data_length_o,
  output logic [15:0] head_category_o,
  output logic [31:0] head_size_o,
  output logic [23:0] head_rate_o,
  output logic        last_o
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NW = $clog2(MAX_PACKETS_PER_TICK + 1);

  function automatic logic [15:0] nz(input logic [15:0] p);
    nz = (p == '0) ? 16'd1 : p;
  endfunction

  // config
  logic [23:0] min_rate_q;
  logic [15:0] min_pkt_q, max_pkt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_rate_q <= 24'd1000;
      min_pkt_q  <= 16'd500;
      max_pkt_q  <= 16'd1100;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_RATE: min_rate_q <= cfg_data_i;
        CFG_MIN_PKT:  min_pkt_q  <= cfg_data_i[15:0];
        CFG_MAX_PKT:  max_pkt_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // control state
  logic [AW-1:0]  head_q;
  logic [CW-1:0]  count_q, scan_q;
  logic [31:0]    rp_q, credit_q;
  logic           fin_q;
  logic [23:0]    cur_q;
  logic [15:0]    owing_q, elapsed_q, pkt_q;
  logic [14:0]    next_id_q;
  logic [NW-1:0]  n_q, i_q;
  logic           out_valid_q;

  // queue memory
  entry_t         mem [QUEUE_DEPTH];
  entry_t         rd_q;
  logic [AW-1:0]  rd_addr, wr_addr, scan_addr, head_nx;
  logic [CW:0]    tail_sum, scan_sum;
  logic           wr_en, add_zero, add_full;

  always_comb begin
    tail_sum  = (CW+1)'(head_q) + (CW+1)'(count_q);
    scan_sum  = (CW+1)'(head_q) + (CW+1)'(scan_q);
    wr_addr   = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
    scan_addr = (scan_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                AW'(scan_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(scan_sum);
    head_nx   = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
    rd_addr   = (cmd_i.op == OP_SCAN_RD) ? scan_addr : head_q;
    add_zero  = (total_size_i == '0);
    add_full  = (count_q >= CW'(QUEUE_DEPTH));
    wr_en     = (cmd_i.op == OP_ADD) && !add_zero && !add_full;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= '{id: next_id_q, size: total_size_i, rate: send_rate_i,
                        category: category_i};
    end
    rd_q <= mem[rd_addr];
  end

  // packet size
  logic [15:0]       mn, mx, span, pkt_fix, pkt_int;
  logic [19:0]       lo, hi, ofs;
  logic              ge_hi, le_lo;
  logic [35:0]       ip_prod;

  always_comb begin
    mn        = min_pkt_q;
    mx        = (max_pkt_q < min_pkt_q) ? min_pkt_q : max_pkt_q;
    lo        = {4'b0, mn} * LO_MUL;
    hi        = {4'b0, mx} * HI_MUL;
    ge_hi     = cur_q >= {4'b0, hi};
    le_lo     = cur_q <= {4'b0, lo};
    span      = mx - mn;
    ofs       = cur_q[19:0] - lo;
    ip_prod   = {20'b0, span} * {16'b0, ofs};
    pkt_fix   = nz(ge_hi ? mx : mn);
  end

  // credit: rate = 1000*q + r, so elapsed*rate/1000 = elapsed*q + elapsed*r/1000
  logic [14:0] rq_q;
  logic [30:0] eq_q;
  logic [25:0] er_q;
  logic [48:0] q_prod;
  logic [24:0] q_thou;
  logic [9:0]  r_rem;
  logic [52:0] f_prod;
  logic [31:0] credit_nx;

  always_comb begin
    q_prod    = {25'b0, cur_q} * {24'b0, RCP_RATE};
    q_thou    = {10'b0, rq_q} * {15'b0, MS_PER_S};
    r_rem     = 10'(cur_q - q_thou[23:0]);
    f_prod    = {27'b0, er_q} * {26'b0, RCP_FRAC};
    credit_nx = {1'b0, eq_q} + {15'b0, f_prod[52:36]} + {16'b0, owing_q};
  end

  // divider
  logic             div_start, div_done;
  logic [DIV_W-1:0] div_a, div_quo;
  logic [DSR_W-1:0] div_b, div_rem;

  always_comb begin
    pkt_int   = nz(mn + div_quo[15:0]);
    div_start = 1'b0;
    div_a     = {8'b0, credit_q};
    div_b     = {4'b0, pkt_fix};
    unique case (cmd_i.op)
      OP_PKT: begin
        div_start = 1'b1;
        if (!ge_hi && !le_lo) begin
          div_a = {4'b0, ip_prod};
          div_b = hi - lo;
        end
      end
      OP_PKT_DONE: begin
        div_start = 1'b1;
        div_b     = {4'b0, pkt_int};
      end
      default: ;
    endcase
  end

  rpts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // packet cut
  logic        is_head, is_tail, pk_last;
  logic [15:0] hdr, maxd, len;
  logic [31:0] remain;
  logic [2:0]  pk_kind;

  always_comb begin
    is_head = (rp_q == '0);
    is_tail = !is_head && (rp_q == rd_q.size);
    priority if (is_head) begin
      hdr = HDR_HEAD; pk_kind = RK_HEAD;
    end else if (is_tail) begin
      hdr = HDR_TAIL; pk_kind = RK_TAIL;
    end else begin
      hdr = HDR_BODY; pk_kind = RK_BODY;
    end
    maxd    = (pkt_q > hdr + PAY_MIN) ? pkt_q - hdr : PAY_MIN;
    remain  = rd_q.size - rp_q;
    len     = (remain > {16'b0, maxd}) ? maxd : remain[15:0];
    pk_last = (i_q + 1'b1 == n_q) || is_tail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      count_q   <= '0;
      scan_q    <= '0;
      rp_q      <= '0;
      fin_q     <= 1'b0;
      cur_q     <= '0;
      owing_q   <= '0;
      next_id_q <= '0;
      n_q       <= '0;
      i_q       <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_ADD: begin
          if (wr_en) begin
            count_q   <= count_q + 1'b1;
            next_id_q <= next_id_q + 1'b1;
            if (send_rate_i > cur_q) cur_q <= send_rate_i;
          end
        end
        OP_CLR_OWING: owing_q <= '0;
        OP_POP: begin
          head_q  <= head_nx;
          count_q <= count_q - 1'b1;
          rp_q    <= '0;
          fin_q   <= 1'b0;
          cur_q   <= min_rate_q;
          scan_q  <= '0;
          if (count_q == CW'(1)) owing_q <= '0;
        end
        OP_FLOOR: if (cur_q < min_rate_q) cur_q <= min_rate_q;
        OP_SCAN_CMP: begin
          if (rd_q.rate > cur_q) cur_q <= rd_q.rate;
          scan_q <= scan_q + 1'b1;
        end
        OP_CRED_DONE: begin
          owing_q <= div_rem[15:0];
          n_q     <= (div_quo >= DIV_W'(MAX_PACKETS_PER_TICK)) ?
                     NW'(MAX_PACKETS_PER_TICK) : div_quo[NW-1:0];
          i_q     <= '0;
        end
        OP_EMIT: begin
          rp_q <= rp_q + {16'b0, len};
          i_q  <= i_q + 1'b1;
          if (is_tail) fin_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload holding registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_TICK:     elapsed_q <= elapsed_ms_i;
      OP_MUL:      rq_q      <= q_prod[48:34];
      OP_FRAC: begin
        eq_q <= {15'b0, elapsed_q} * {16'b0, rq_q};
        er_q <= {10'b0, elapsed_q} * {16'b0, r_rem};
      end
      OP_CREDIT:   credit_q  <= credit_nx;
      OP_PKT:      pkt_q     <= pkt_fix;
      OP_PKT_DONE: pkt_q     <= pkt_int;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_ADD || cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ADD) begin
      result_kind_o   <= add_zero ? RK_ZERO : (add_full ? RK_FULL : RK_ADDED);
      transfer_id_o   <= wr_en ? next_id_q : '0;
      data_offset_o   <= '0;
      data_length_o   <= '0;
      head_category_o <= '0;
      head_size_o     <= '0;
      head_rate_o     <= '0;
      last_o          <= 1'b1;
    end else if (cmd_i.op == OP_EMIT) begin
      result_kind_o   <= pk_kind;
      transfer_id_o   <= rd_q.id;
      data_offset_o   <= rp_q;
      data_length_o   <= len;
      head_category_o <= is_head ? rd_q.category : '0;
      head_size_o     <= is_head ? rd_q.size : '0;
      head_rate_o     <= is_head ? rd_q.rate : '0;
      last_o          <= pk_last;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.empty      = (count_q == '0);
    status_o.pop_cond   = (rp_q == rd_q.size) && fin_q;
    status_o.count_one  = (count_q == CW'(1));
    status_o.scan_last  = (scan_q == count_q - 1'b1);
    status_o.div_done   = div_done;
    status_o.pkt_interp = !ge_hi && !le_lo;
    status_o.emit_end   = (i_q == n_q) || fin_q;
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

### design/rpts_ctrl.sv
// Controller: sequences adds, pops, rate rescans, divisions and packet emission.
module rpts_ctrl import rpts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    kind_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_FRONT    = 11'b00000000010,
    S_SCAN_RD  = 11'b00000000100,
    S_SCAN_CMP = 11'b00000001000,
    S_MUL      = 11'b00000010000,
    S_FRAC     = 11'b00000100000,
    S_CREDIT   = 11'b00001000000,
    S_PKT      = 11'b00010000000,
    S_DIV_PKT  = 11'b00100000000,
    S_DIV_CRED = 11'b01000000000,
    S_EMIT     = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign in_stall_o = (state_q != S_IDLE) || !status_i.out_free;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (kind_i) begin
            cmd_o.op = OP_ADD;
          end else if (status_i.empty) begin
            cmd_o.op = OP_CLR_OWING;
          end else begin
            cmd_o.op = OP_TICK;
            state_d  = S_FRONT;
          end
        end
      end
      S_FRONT: begin
        if (status_i.pop_cond) begin
          cmd_o.op = OP_POP;
          state_d  = status_i.count_one ? S_IDLE : S_SCAN_RD;
        end else begin
          cmd_o.op = OP_FLOOR;
          state_d  = S_MUL;
        end
      end
      S_SCAN_RD: begin
        cmd_o.op = OP_SCAN_RD;
        state_d  = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.op = OP_SCAN_CMP;
        state_d  = status_i.scan_last ? S_FRONT : S_SCAN_RD;
      end
      S_MUL: begin
        cmd_o.op = OP_MUL;
        state_d  = S_FRAC;
      end
      S_FRAC: begin
        cmd_o.op = OP_FRAC;
        state_d  = S_CREDIT;
      end
      S_CREDIT: begin
        cmd_o.op = OP_CREDIT;
        state_d  = S_PKT;
      end
      S_PKT: begin
        cmd_o.op = OP_PKT;
        state_d  = status_i.pkt_interp ? S_DIV_PKT : S_DIV_CRED;
      end
      S_DIV_PKT: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_PKT_DONE;
          state_d  = S_DIV_CRED;
        end
      end
      S_DIV_CRED: begin
        if (status_i.div_done) begin
          cmd_o.op = OP_CRED_DONE;
          state_d  = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.emit_end) begin
          state_d = S_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/rate_paced_transfer_segmenter.sv
// Top level of the rate paced transfer segmenter: controller plus datapath.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o | kind, elapsed_ms, total_size, send_rate, category
//   out     | out_valid_o/out_stall_i | result_kind, transfer_id, data_offset, ...
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A tick runs the credit division on the shared radix-2 divider and then emits its packets;
// an interpolated packet size adds a packet-size division on the same divider before it.
// A pop rescans the rates of the remaining entries; a pop that empties the queue ends the
// tick. Output stalls hold the tick while packets wait.
// Reset is asynchronous and active low; the queue needs no clearing pass.
// A stalled output holds the result register and the input stays stalled.
module rate_paced_transfer_segmenter import rpts_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH          = 16,
  parameter int unsigned MAX_PACKETS_PER_TICK = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [15:0] elapsed_ms_i,
  input  logic [31:0] total_size_i,
  input  logic [23:0] send_rate_i,
  input  logic [15:0] category_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  result_kind_o,
  output logic [14:0] transfer_id_o,
  output logic [31:0] data_offset_o,
  output logic [15:0] data_length_o,
  output logic [15:0] head_category_o,
  output logic [31:0] head_size_o,
  output logic [23:0] head_rate_o,
  output logic        last_o
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  rpts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rpts_dp #(
    .QUEUE_DEPTH          (QUEUE_DEPTH),
    .MAX_PACKETS_PER_TICK (MAX_PACKETS_PER_TICK)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .total_size_i    (total_size_i),
    .send_rate_i     (send_rate_i),
    .category_i      (category_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .result_kind_o   (result_kind_o),
    .transfer_id_o   (transfer_id_o),
    .data_offset_o   (data_offset_o),
    .data_length_o   (data_length_o),
    .head_category_o (head_category_o),
    .head_size_o     (head_size_o),
    .head_rate_o     (head_rate_o),
    .last_o          (last_o)
  );

endmodule

### design/rpts_chk.sv
// Port-level checker for the segmenter, bound to the top level.
module rpts_chk import rpts_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        kind_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  result_kind_o,
  input logic [31:0] data_offset_o,
  input logic [15:0] data_length_o,
  input logic [15:0] head_category_o,
  input logic [31:0] head_size_o,
  input logic [23:0] head_rate_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_add_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i |=> out_valid_o && last_o &&
      (result_kind_o == RK_ADDED || result_kind_o == RK_FULL || result_kind_o == RK_ZERO))
    else $error("add item without its status result");

  a_head_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RK_HEAD |-> data_offset_o == '0)
    else $error("head packet at nonzero offset");

  a_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RK_BODY || result_kind_o == RK_TAIL) |->
      head_size_o == '0 && head_rate_o == '0 && head_category_o == '0)
    else $error("head fields set on body or tail packet");

  a_add_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == RK_ADDED || result_kind_o == RK_FULL ||
      result_kind_o == RK_ZERO) |-> data_length_o == '0 && last_o)
    else $error("add status carries packet data");

endmodule

bind rate_paced_transfer_segmenter rpts_chk u_rpts_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .kind_i          (kind_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_kind_o   (result_kind_o),
  .data_offset_o   (data_offset_o),
  .data_length_o   (data_length_o),
  .head_category_o (head_category_o),
  .head_size_o     (head_size_o),
  .head_rate_o     (head_rate_o),
  .last_o          (last_o)
);

### bench/rate_paced_transfer_segmenter_tb.sv
// Self-checking testbench for the rate paced transfer segmenter.
module rate_paced_transfer_segmenter_tb;
  import rpts_pkg::*;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned PKT_CAP = 64;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [14:0] id;
    logic [31:0] offset;
    logic [15:0] length;
    logic [15:0] category;
    logic [31:0] size;
    logic [23:0] rate;
    logic        last;
  } seg_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = 1'b0;
  logic [15:0] elapsed_ms_i = '0;
  logic [31:0] total_size_i = '0;
  logic [23:0] send_rate_i = '0;
  logic [15:0] category_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [14:0] transfer_id_o;
  logic [31:0] data_offset_o;
  logic [15:0] data_length_o;
  logic [15:0] head_category_o;
  logic [31:0] head_size_o;
  logic [23:0] head_rate_o;
  logic        last_o;

  rate_paced_transfer_segmenter uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [23:0] p_min_rate;
  logic [15:0] p_min_pkt, p_max_pkt;
  entry_t      p_queue [QDEPTH];
  logic [3:0]  p_head;
  logic [4:0]  p_count;
  logic [31:0] p_read_pos;
  logic        p_finishing;
  logic [23:0] p_rate;
  logic [15:0] p_owing;
  logic [14:0] p_next_id;

  seg_result_t expected_results[$];
  int          error_count = 0;
  bit          quiet_mode = 0;  // no idling on either side
  longint unsigned cycle_count = 0;

  function automatic logic [31:0] seg_packet_size(logic [23:0] rate);
    longint unsigned mn, mx, lo, hi, p;
    mn = p_min_pkt;
    mx = (p_max_pkt < p_min_pkt) ? p_min_pkt : p_max_pkt;
    lo = mn * 10;
    hi = mx * 15;
    if (rate >= hi) p = mx;
    else if (rate <= lo) p = mn;
    else p = mn + (mx - mn) * (rate - lo) / (hi - lo);
    return (p == 0) ? 32'd1 : p[31:0];
  endfunction

  task automatic add_expected(logic [2:0] k, logic [14:0] id, logic [31:0] off,
                              logic [15:0] len, logic [15:0] cat, logic [31:0] sz,
                              logic [23:0] rt);
    seg_result_t r;
    r = '{k, id, off, len, cat, sz, rt, 1'b0};
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_item(logic knd, logic [15:0] ems, logic [31:0] tsz,
                              logic [23:0] trt, logic [15:0] tcat);
    int n, k;
    longint unsigned credit, pkt;
    logic [31:0] sz, len, hdr, maxd;
    logic [2:0] rk;
    if (knd) begin
      if (tsz == '0) add_expected(RK_ZERO, '0, '0, '0, '0, '0, '0);
      else if (p_count >= QDEPTH) add_expected(RK_FULL, '0, '0, '0, '0, '0, '0);
      else begin
        p_queue[4'(p_head + p_count)] = '{p_next_id, tsz, trt, tcat};
        p_count++;
        add_expected(RK_ADDED, p_next_id, '0, '0, '0, '0, '0);
        p_next_id++;
        if (trt > p_rate) p_rate = trt;
      end
      expected_results[$].last = 1'b1;
      return;
    end
    if (p_count == '0) begin
      p_owing = '0;
      return;
    end
    if (p_read_pos == p_queue[p_head].size && p_finishing) begin
      p_head++;
      p_count--;
      p_read_pos = '0;
      p_finishing = 1'b0;
      p_rate = p_min_rate;
      for (int i = 0; i < p_count; i++)
        if (p_queue[4'(p_head + i)].rate > p_rate) p_rate = p_queue[4'(p_head + i)].rate;
      if (p_count == '0) begin
        p_owing = '0;
        return;
      end
    end
    if (p_rate < p_min_rate) p_rate = p_min_rate;
    credit = longint'(ems) * p_rate / 1000 + p_owing;
    pkt = seg_packet_size(p_rate);
    p_owing = 16'(credit % pkt);
    credit = credit / pkt;
    n = (credit < PKT_CAP) ? int'(credit) : int'(PKT_CAP);
    k = 0;
    for (int i = 0; i < n && !p_finishing; i++) begin
      sz = p_queue[p_head].size;
      if (p_read_pos == '0) begin rk = RK_HEAD; hdr = 32'(HDR_HEAD); end
      else if (p_read_pos == sz) begin
        rk = RK_TAIL; hdr = 32'(HDR_TAIL); p_finishing = 1'b1;
      end else begin rk = RK_BODY; hdr = 32'(HDR_BODY); end
      maxd = (pkt > hdr + 10) ? 32'(pkt) - hdr : 32'd10;
      len = sz - p_read_pos;
      if (len > maxd) len = maxd;
      if (rk == RK_HEAD)
        add_expected(rk, p_queue[p_head].id, p_read_pos, len[15:0],
                     p_queue[p_head].category, sz, p_queue[p_head].rate);
      else add_expected(rk, p_queue[p_head].id, p_read_pos, len[15:0], '0, '0, '0);
      p_read_pos += len;
      k++;
    end
    if (k > 0) expected_results[$].last = 1'b1;
  endtask

  // receiver side: random stall, check each accepted result
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_stall_i <= quiet_mode ? 1'b0 : ($urandom_range(99) < 33);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seg_result_t got, exp_r;
      got = '{result_kind_o, transfer_id_o, data_offset_o, data_length_o,
              head_category_o, head_size_o, head_rate_o, last_o};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        error_count++;
      end else begin
        exp_r = expected_results[0];
        expected_results.delete(0);
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
          if (got.kind !== exp_r.kind)
            $display("%0t:   kind expected %0d actual %0d", $time, exp_r.kind, got.kind);
          if (got.offset !== exp_r.offset || got.length !== exp_r.length)
            $display("%0t:   offset/length expected %0d/%0d actual %0d/%0d", $time,
                     exp_r.offset, exp_r.length, got.offset, got.length);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i)
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rate_paced_transfer_segmenter regression: fail");
      $finish;
    end

  // valid stays up after an accepted item until the next item or an idle cycle replaces it
  task automatic send_item(logic knd, logic [15:0] ems, logic [31:0] tsz,
                           logic [23:0] trt, logic [15:0] tcat);
    while (!quiet_mode && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= knd;
    elapsed_ms_i <= ems;
    total_size_i <= tsz;
    send_rate_i <= trt;
    category_i <= tcat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_item(knd, ems, tsz, trt, tcat);
  endtask

  task automatic send_add(logic [31:0] tsz, logic [23:0] trt);
    send_item(1'b1, 16'($urandom), tsz, trt, 16'($urandom));
  endtask

  task automatic send_tick(logic [15:0] ems);
    send_item(1'b0, ems, $urandom, 24'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);  // a tick may still be busy with no result
  endtask

  // valid stays up across back-to-back writes; set_config drops it
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_MIN_RATE: p_min_rate = val;
      CFG_MIN_PKT:  p_min_pkt = val[15:0];
      CFG_MAX_PKT:  p_max_pkt = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [23:0] mr, logic [15:0] mn, logic [15:0] mx);
    wait_idle();
    write_reg(CFG_MIN_RATE, mr);
    write_reg(CFG_MIN_PKT, 24'(mn));
    write_reg(CFG_MAX_PKT, 24'(mx));
    cfg_valid_i <= 1'b0;
  endtask

  // directed: rejects, full queue, extremes, small and zero-length ticks
  task automatic test_directed();
    send_tick(16'd100);                      // empty queue
    send_add(32'd0, 24'd5000);               // zero size
    send_add(32'd1, 24'd0);
    send_add(32'hFFFF_FFFF, 24'hFF_FFFF);
    for (int i = 0; i < 15; i++) send_add(32'($urandom_range(1, 3000)), 24'($urandom));
    send_add(32'd100, 24'd1);                // queue full
    send_add(32'd0, 24'd1);                  // zero checked before full
    send_tick(16'd0);
    send_tick(16'hFFFF);
    send_tick(16'd1);
    send_tick(16'd65535);
  endtask

  // tick at the longest elapsed time to drain the queue, stopping when it is empty or after 20 ticks
  task automatic test_drain();
    for (int i = 0; i < 20 && p_count != '0; i++) send_tick(16'hFFFF);
  endtask

  task automatic test_random(int items);
    int r;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (r < 35)
        send_add(($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(1, 5000)),
                 ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40000)));
      else if (r < 38) send_add(32'd0, 24'($urandom));
      else send_tick(($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400)));
    end
  endtask

  initial begin
    p_min_rate = 24'd1000;
    p_min_pkt = 16'd500;
    p_max_pkt = 16'd1100;
    p_head = '0;
    p_count = '0;
    p_read_pos = '0;
    p_finishing = 1'b0;
    p_rate = '0;
    p_owing = '0;
    p_next_id = '0;
    foreach (p_queue[i]) p_queue[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_drain();
    test_random(70);
    set_config(24'd1, 16'd16, 16'd16);                       // extremes, low end
    test_random(40);
    set_config(24'hFF_FFFF, 16'd65535, 16'd65535);           // extremes, high end
    test_random(30);
    test_drain();
    set_config(24'd2000, 16'd900, 16'd100);                  // max below min
    test_random(40);
    set_config(24'd500, 16'd16, 16'd2000);                   // wide interpolation
    quiet_mode = 1;
    test_random(50);
    quiet_mode = 0;
    test_random(30);
    test_drain();

    wait_idle();
    if (error_count == 0) $display("rate_paced_transfer_segmenter regression: pass");
    else $display("rate_paced_transfer_segmenter regression: fail");
    $finish;
  end
endmodule
